// ===== hw/rtl/fvn_pkg.sv =====
// Package for the fractal value noise block: widths, reset values, register codes
// and the reciprocal table used by the normalising divide. No dependencies.
`default_nettype none
package fvn_pkg;

    localparam int TABLE_SIZE_DEF = 256;
    localparam int MAX_OCT_DEF    = 8;

    localparam int FRAC_W     = 24;
    localparam int COORD_W    = 32;
    localparam int FREQ_W     = 24;
    localparam int OCT_W      = 4;
    localparam int IDX_W      = 8;
    localparam int VAL_W      = 8;
    localparam int NOISE_W    = 16;
    localparam int XS_W       = 48;
    localparam int LAT_W      = 32;
    localparam int W_W        = 25;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam int AMP_SHIFT  = 16;
    localparam int NORM_BASE  = 33;

    localparam logic [FREQ_W-1:0] FREQ_RESET = 24'd65536;
    localparam logic [OCT_W-1:0]  OCT_RESET  = 4'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FREQUENCY    = 1'b0,
        CFG_OCTAVE_COUNT = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } t_op;

    // floor((2^32 - 1) / (2^n - 1)) for n = 1..16
    localparam logic [31:0] RECIP [0:16] = '{
        32'hFFFF_FFFF,
        32'(64'hFFFF_FFFF / 64'd1),
        32'(64'hFFFF_FFFF / 64'd3),
        32'(64'hFFFF_FFFF / 64'd7),
        32'(64'hFFFF_FFFF / 64'd15),
        32'(64'hFFFF_FFFF / 64'd31),
        32'(64'hFFFF_FFFF / 64'd63),
        32'(64'hFFFF_FFFF / 64'd127),
        32'(64'hFFFF_FFFF / 64'd255),
        32'(64'hFFFF_FFFF / 64'd511),
        32'(64'hFFFF_FFFF / 64'd1023),
        32'(64'hFFFF_FFFF / 64'd2047),
        32'(64'hFFFF_FFFF / 64'd4095),
        32'(64'hFFFF_FFFF / 64'd8191),
        32'(64'hFFFF_FFFF / 64'd16383),
        32'(64'hFFFF_FFFF / 64'd32767),
        32'(64'hFFFF_FFFF / 64'd65535)
    };

endpackage
`default_nettype wire

// ===== hw/rtl/fvn_if.sv =====
// Valid/ready channel interfaces for the fractal value noise block.
// Depends on fvn_pkg for field widths.
`default_nettype none
interface fvn_in_if;
    import fvn_pkg::*;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [COORD_W-1:0] x_coord;
    logic [COORD_W-1:0] y_coord;
    logic [IDX_W-1:0]   table_index;
    logic [VAL_W-1:0]   table_value;
    modport source (output valid, operation, x_coord, y_coord, table_index, table_value,
                    input ready);
    modport sink   (input valid, operation, x_coord, y_coord, table_index, table_value,
                    output ready);
endinterface

interface fvn_out_if;
    import fvn_pkg::*;
    logic               valid;
    logic               ready;
    logic [NOISE_W-1:0] noise_value;
    modport source (output valid, noise_value, input ready);
    modport sink   (input valid, noise_value, output ready);
endinterface

interface fvn_cfg_if;
    import fvn_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fractal_value_noise_2d.sv =====
// Top level of the fractal value noise block: input and config registers, coordinate
// scaling, octave lanes, weighted sum tree and normalising divide.
// Depends on fvn_pkg, fvn_if, fvn_octave and fvn_ram.
//
// One beat is taken every cycle unless the output stalls or the tables are
// being loaded. An evaluation beat returns its noise_value; table-write beats
// return nothing. All octaves run side by side, each with three copies of the
// permutation table, and a write updates every copy in pipeline order so that
// each evaluation sees exactly the writes accepted before it. TABLE_SIZE must
// be a power of two. After reset the tables are loaded with the identity in a
// pass over every entry, during which input is not taken; configuration
// writes are taken at any time. A stalled output holds the whole pipeline.
`default_nettype none
module fractal_value_noise_2d
    import fvn_pkg::*;
#(
    parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
    parameter int MAX_OCTAVES = MAX_OCT_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fvn_in_if.sink    i_in,
    fvn_cfg_if.sink   i_cfg,
    fvn_out_if.source o_out
);
    localparam int TW   = $clog2(TABLE_SIZE);
    localparam int L    = $clog2(MAX_OCTAVES);
    localparam int NL   = 1 << L;
    localparam int SUMW = XS_W + L;
    localparam int NW   = $clog2(MAX_OCTAVES + 1);
    localparam int NST  = 10 + L;

    logic [FREQ_W-1:0] r_freq;
    logic [OCT_W-1:0]  r_oct;
    logic [NW-1:0]     w_neff;
    logic [5:0]        w_sh;
    logic [NOISE_W-1:0] w_div;
    logic [31:0]       w_recip;

    logic w_en, w_in_acc;
    logic r_clearing;
    logic [TW-1:0] r_clr_cnt;

    logic r_vld [0:NST-1];
    logic r_ev  [0:NST-1];

    logic [COORD_W-1:0] r_x0, r_y0;
    logic [TW-1:0]      r_idx0, r_idx1, r_idx2;
    logic [VAL_W-1:0]   r_val0, r_val1, r_val2;
    logic               r_wok0, r_wok1, r_wok2;
    logic [XS_W-1:0]    r_xs, r_ys;
    logic [COORD_W+FREQ_W-1:0] w_xp, w_yp;

    logic              w_t_we, w_v_we;
    logic [TW-1:0]     w_t_addr, w_v_addr;
    logic [VAL_W-1:0]  w_t_data, w_v_data;

    logic [LAT_W-1:0]  w_n   [0:MAX_OCTAVES-1];
    logic [SUMW-1:0]   r_lvl [0:L][0:NL-1];
    logic [SUMW-1:0]   w_shifted;

    logic [31:0]       r_t, r_t2;
    logic [63:0]       w_prod;
    logic [NOISE_W-1:0] r_q0;
    logic [31:0]       w_qd, w_rem;

    logic               r_out_vld;
    logic [NOISE_W-1:0] r_out_data;

    always_comb begin
        if (r_oct == '0) begin
            w_neff = NW'(1);
        end else if (32'(r_oct) > 32'(MAX_OCTAVES)) begin
            w_neff = NW'(MAX_OCTAVES);
        end else begin
            w_neff = NW'(r_oct);
        end
        w_sh    = 6'(NORM_BASE) - 6'(w_neff);
        w_div   = NOISE_W'((17'(1) << w_neff) - 17'd1);
        w_recip = RECIP[5'(w_neff)];
    end

    assign w_en        = !r_out_vld || o_out.ready;
    assign i_in.ready  = w_en && !r_clearing;
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= FREQ_RESET;
            r_oct  <= OCT_RESET;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                CFG_FREQUENCY:    r_freq <= i_cfg.data[FREQ_W-1:0];
                CFG_OCTAVE_COUNT: r_oct  <= i_cfg.data[OCT_W-1:0];
                default:          r_oct  <= r_oct;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            r_clr_cnt <= r_clr_cnt + TW'(1);
            if (r_clr_cnt == TW'(TABLE_SIZE - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NST; i++) begin
                r_vld[i] <= 1'b0;
                r_ev[i]  <= 1'b0;
            end
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= w_in_acc;
            r_ev[0]  <= i_in.operation == OP_EVAL;
            for (int i = 1; i < NST; i++) begin
                r_vld[i] <= r_vld[i-1];
                r_ev[i]  <= r_ev[i-1];
            end
            r_out_vld <= r_vld[NST-1] && r_ev[NST-1];
        end
    end

    assign w_xp = (COORD_W+FREQ_W)'(r_x0) * (COORD_W+FREQ_W)'(r_freq);
    assign w_yp = (COORD_W+FREQ_W)'(r_y0) * (COORD_W+FREQ_W)'(r_freq);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x0   <= i_in.x_coord;
            r_y0   <= i_in.y_coord;
            r_idx0 <= TW'(i_in.table_index);
            r_val0 <= i_in.table_value;
            r_wok0 <= 32'(i_in.table_index) < 32'(TABLE_SIZE);
            r_xs   <= w_xp[8 +: XS_W];
            r_ys   <= w_yp[8 +: XS_W];
            r_idx1 <= r_idx0;
            r_val1 <= r_val0;
            r_wok1 <= r_wok0;
            r_idx2 <= r_idx1;
            r_val2 <= r_val1;
            r_wok2 <= r_wok1;
        end
    end

    always_comb begin
        if (r_clearing) begin
            w_t_we   = 1'b1;
            w_t_addr = r_clr_cnt;
            w_t_data = VAL_W'(r_clr_cnt);
            w_v_we   = 1'b1;
            w_v_addr = r_clr_cnt;
            w_v_data = VAL_W'(r_clr_cnt);
        end else begin
            w_t_we   = w_en && r_vld[1] && !r_ev[1] && r_wok1;
            w_t_addr = r_idx1;
            w_t_data = r_val1;
            w_v_we   = w_en && r_vld[2] && !r_ev[2] && r_wok2;
            w_v_addr = r_idx2;
            w_v_data = r_val2;
        end
    end

    for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
        fvn_octave #(.TABLE_SIZE(TABLE_SIZE), .K(k)) u_oct (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_xs     (r_xs),
            .i_ys     (r_ys),
            .i_t_we   (w_t_we),
            .i_t_addr (w_t_addr),
            .i_t_data (w_t_data),
            .i_v_we   (w_v_we),
            .i_v_addr (w_v_addr),
            .i_v_data (w_v_data),
            .o_n      (w_n[k])
        );
    end

    for (genvar i = 0; i < NL; i++) begin : g_leaf
        if (i < MAX_OCTAVES) begin : g_used
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_lvl[0][i] <= (32'(i) < 32'(w_neff))
                                 ? (SUMW'(w_n[i]) << (AMP_SHIFT - i)) : '0;
                end
            end
        end else begin : g_pad
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_lvl[0][i] <= '0;
                end
            end
        end
    end

    for (genvar j = 1; j <= L; j++) begin : g_lvl
        for (genvar i = 0; i < (NL >> j); i++) begin : g_add
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_lvl[j][i] <= r_lvl[j-1][2*i] + r_lvl[j-1][2*i+1];
                end
            end
        end
    end

    assign w_shifted = r_lvl[L][0] >> w_sh;
    assign w_prod    = 64'(r_t) * 64'(w_recip);
    assign w_qd      = 32'(r_q0) * 32'(w_div);
    assign w_rem     = r_t2 - w_qd;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t        <= w_shifted[31:0];
            r_t2       <= r_t;
            r_q0       <= w_prod[32 +: NOISE_W];
            r_out_data <= (w_rem >= 32'(w_div)) ? r_q0 + NOISE_W'(1) : r_q0;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.noise_value = r_out_data;
endmodule
`default_nettype wire

// ===== hw/rtl/fvn_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`default_nettype none
module fvn_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [DATA_W-1:0]        o_rdata_a,
    output logic      [DATA_W-1:0]        o_rdata_b
);
    logic [DATA_W-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end
endmodule
`default_nettype wire

// ===== hw/rtl/fvn_octave.sv =====
// One noise octave lane: lattice hash through table replicas, smoothstep, bilinear blend.
// Depends on fvn_pkg and fvn_ram. Five register stages from scaled point to octave value.
`default_nettype none
module fvn_octave
    import fvn_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int K          = 0
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [XS_W-1:0]               i_xs,
    input  wire logic [XS_W-1:0]               i_ys,
    input  wire logic                          i_t_we,
    input  wire logic [$clog2(TABLE_SIZE)-1:0] i_t_addr,
    input  wire logic [VAL_W-1:0]              i_t_data,
    input  wire logic                          i_v_we,
    input  wire logic [$clog2(TABLE_SIZE)-1:0] i_v_addr,
    input  wire logic [VAL_W-1:0]              i_v_data,
    output logic      [LAT_W-1:0]              o_n
);
    localparam int TW   = $clog2(TABLE_SIZE);
    localparam int SW   = XS_W + K;
    localparam int PW   = FRAC_W + 2;
    localparam logic [PW-1:0]  THREE = PW'(3) << FRAC_W;
    localparam logic [W_W-1:0] ONE   = W_W'(1) << FRAC_W;

    logic [SW-1:0]     w_xsh, w_ysh;
    logic [FRAC_W-1:0] w_fx, w_fy;
    logic [TW-1:0]     w_xi, w_yi;
    logic [2*FRAC_W-1:0] w_sqx, w_sqy;

    logic [TW-1:0]       r_xi;
    logic [FRAC_W-1:0]   r_sqx, r_sqy;
    logic [PW-1:0]       r_polx, r_poly;
    logic [VAL_W-1:0]    w_ta, w_tb;
    logic [FRAC_W+PW-1:0] w_px, w_py;
    logic [TW-1:0]       w_a00, w_a10, w_a01, w_a11;

    logic [W_W-1:0]      r_wx, r_wy;
    logic [VAL_W-1:0]    w_c00, w_c10, w_c01, w_c11;
    logic [LAT_W-1:0]    w_lo, w_hi;

    logic [LAT_W-1:0]    r_lo, r_hi;
    logic [W_W-1:0]      r_wy2;

    logic [LAT_W+W_W-1:0] r_p1, r_p2;
    logic [LAT_W+W_W-1:0] w_psum;
    logic [LAT_W-1:0]     r_n;

    always_comb begin
        w_xsh = SW'(i_xs) << K;
        w_ysh = SW'(i_ys) << K;
        w_fx  = w_xsh[FRAC_W-1:0];
        w_fy  = w_ysh[FRAC_W-1:0];
        w_xi  = w_xsh[FRAC_W +: TW];
        w_yi  = w_ysh[FRAC_W +: TW];
        w_sqx = (2*FRAC_W)'(w_fx) * (2*FRAC_W)'(w_fx);
        w_sqy = (2*FRAC_W)'(w_fy) * (2*FRAC_W)'(w_fy);
    end

    fvn_ram #(.DATA_W(VAL_W), .DEPTH(TABLE_SIZE)) u_ram_t (
        .i_clk     (i_clk),
        .i_we      (i_t_we),
        .i_waddr   (i_t_addr),
        .i_wdata   (i_t_data),
        .i_re      (i_en),
        .i_raddr_a (w_yi),
        .i_raddr_b (w_yi + TW'(1)),
        .o_rdata_a (w_ta),
        .o_rdata_b (w_tb)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xi   <= w_xi;
            r_sqx  <= w_sqx[2*FRAC_W-1:FRAC_W];
            r_sqy  <= w_sqy[2*FRAC_W-1:FRAC_W];
            r_polx <= THREE - {1'b0, w_fx, 1'b0};
            r_poly <= THREE - {1'b0, w_fy, 1'b0};
        end
    end

    always_comb begin
        w_px  = (FRAC_W+PW)'(r_sqx) * (FRAC_W+PW)'(r_polx);
        w_py  = (FRAC_W+PW)'(r_sqy) * (FRAC_W+PW)'(r_poly);
        w_a00 = TW'(w_ta) + r_xi;
        w_a10 = TW'(w_ta) + r_xi + TW'(1);
        w_a01 = TW'(w_tb) + r_xi;
        w_a11 = TW'(w_tb) + r_xi + TW'(1);
    end

    fvn_ram #(.DATA_W(VAL_W), .DEPTH(TABLE_SIZE)) u_ram_lo (
        .i_clk     (i_clk),
        .i_we      (i_v_we),
        .i_waddr   (i_v_addr),
        .i_wdata   (i_v_data),
        .i_re      (i_en),
        .i_raddr_a (w_a00),
        .i_raddr_b (w_a10),
        .o_rdata_a (w_c00),
        .o_rdata_b (w_c10)
    );

    fvn_ram #(.DATA_W(VAL_W), .DEPTH(TABLE_SIZE)) u_ram_hi (
        .i_clk     (i_clk),
        .i_we      (i_v_we),
        .i_waddr   (i_v_addr),
        .i_wdata   (i_v_data),
        .i_re      (i_en),
        .i_raddr_a (w_a01),
        .i_raddr_b (w_a11),
        .o_rdata_a (w_c01),
        .o_rdata_b (w_c11)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wx <= w_px[FRAC_W +: W_W];
            r_wy <= w_py[FRAC_W +: W_W];
        end
    end

    always_comb begin
        w_lo = LAT_W'(w_c00) * LAT_W'(ONE - r_wx) + LAT_W'(w_c10) * LAT_W'(r_wx);
        w_hi = LAT_W'(w_c01) * LAT_W'(ONE - r_wx) + LAT_W'(w_c11) * LAT_W'(r_wx);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo  <= w_lo;
            r_hi  <= w_hi;
            r_wy2 <= r_wy;
            r_p1  <= (LAT_W+W_W)'(r_lo) * (LAT_W+W_W)'(ONE - r_wy2);
            r_p2  <= (LAT_W+W_W)'(r_hi) * (LAT_W+W_W)'(r_wy2);
            r_n   <= w_psum[FRAC_W +: LAT_W];
        end
    end

    assign w_psum = r_p1 + r_p2;
    assign o_n    = r_n;
endmodule
`default_nettype wire
